>>> hw/rtl/cbc_pkg.sv
// Shared types, codes and sizes of the cartridge bank controller.
`timescale 1ns / 1ps

package cbc_pkg;

	// Default memory sizes (bytes, powers of two)
	localparam int ROM_BYTES_DEF = 65536;
	localparam int RAM_BYTES_DEF = 32768;

	// Full-width offsets before wrapping to the memory size
	localparam int ROM_OFF_W = 21;   // 7-bit bank and 14-bit window offset
	localparam int RAM_OFF_W = 15;   // 2-bit bank and 13-bit window offset

	// Request commands
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;

	// Bus regions, selected by address bits 15:13
	localparam logic [2:0] RGN_RAM_EN   = 3'd0;
	localparam logic [2:0] RGN_ROM_LO   = 3'd1;
	localparam logic [2:0] RGN_ROM_HI   = 3'd2;
	localparam logic [2:0] RGN_ROM_HI2  = 3'd3;
	localparam logic [2:0] RGN_CART_RAM = 3'd5;

	// Source of read data
	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_ROM  = 2'd1;
	localparam logic [1:0] SRC_RAM  = 2'd2;

	// Config register indexes
	localparam logic REG_RAM_PRESENT = 1'b0;

	// RAM enable key in the low nibble
	localparam logic [3:0] RAM_EN_KEY = 4'hA;

	localparam logic [7:0] OPEN_BUS = 8'hFF;

	// Memory accesses decoded from one request
	typedef struct packed {
		logic                 rom_rd;
		logic                 rom_wr;
		logic                 ram_rd;
		logic                 ram_wr;
		logic [1:0]           src;
		logic [ROM_OFF_W-1:0] rom_off;
		logic [RAM_OFF_W-1:0] ram_off;
	} acc_t;

endpackage

>>> hw/rtl/cbc_if.sv
// Request and response channel interfaces of the cartridge bank controller.
`timescale 1ns / 1ps

interface cbc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] address;
	logic [7:0]  value;
	logic [15:0] image_address;

	modport source (output valid, output cmd, output address, output value,
		output image_address, input ready);
	modport sink (input valid, input cmd, input address, input value,
		input image_address, output ready);
endinterface

interface cbc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

>>> hw/rtl/cbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps

module cbc_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/cbc_decode.sv
// Bank registers and translation of bus requests into memory accesses.
`timescale 1ns / 1ps

module cbc_decode #(
	parameter int RomBytes = cbc_pkg::ROM_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         cmd,
	input  logic [15:0]        address,
	input  logic [7:0]         value,
	input  logic [15:0]        image_address,
	input  logic               ram_present,
	output cbc_pkg::acc_t      acc
);

	logic [6:0] rom_bank_q;
	logic [1:0] ram_bank_q;
	logic       ram_enabled_q;
	logic       banking_mode_q;

	logic [2:0] region;
	logic       ram_open;
	logic       load_ok;
	logic [4:0] bank_low;
	logic [6:0] window_bank;

	assign region   = address[15:13];
	assign ram_open = ram_enabled_q && ram_present;
	assign load_ok  = (32'(image_address) < 32'(RomBytes));
	assign bank_low = (value[4:0] == 5'd0) ? 5'd1 : value[4:0];

	// Bank 0 fixed in the low window, selected bank in the high window
	assign window_bank = address[14] ? rom_bank_q : 7'd0;

	// Translate the request into memory accesses
	always_comb begin
		acc         = '0;
		acc.src     = cbc_pkg::SRC_NONE;
		acc.ram_off = {ram_bank_q, address[12:0]};
		acc.rom_off = {window_bank, address[13:0]};
		unique case (cmd)
			cbc_pkg::CMD_READ: begin
				if (!address[15]) begin
					acc.rom_rd = 1'b1;
					acc.src    = cbc_pkg::SRC_ROM;
				end else if (region == cbc_pkg::RGN_CART_RAM && ram_open) begin
					acc.ram_rd = 1'b1;
					acc.src    = cbc_pkg::SRC_RAM;
				end
			end
			cbc_pkg::CMD_WRITE: begin
				acc.ram_wr = (region == cbc_pkg::RGN_CART_RAM) && ram_open;
			end
			cbc_pkg::CMD_LOAD: begin
				acc.rom_wr  = load_ok;
				acc.rom_off = cbc_pkg::ROM_OFF_W'(image_address);
			end
			default: begin
			end
		endcase
	end

	// Update the banking registers on bus writes below 0x8000
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q     <= 7'd1;
			ram_bank_q     <= 2'd0;
			ram_enabled_q  <= 1'b0;
			banking_mode_q <= 1'b0;
		end else if (accept && cmd == cbc_pkg::CMD_WRITE) begin
			unique case (region)
				cbc_pkg::RGN_RAM_EN: begin
					ram_enabled_q <= (value[3:0] == cbc_pkg::RAM_EN_KEY);
				end
				cbc_pkg::RGN_ROM_LO: begin
					rom_bank_q <= {rom_bank_q[6:5], bank_low};
				end
				cbc_pkg::RGN_ROM_HI: begin
					if (banking_mode_q) begin
						ram_bank_q <= value[1:0];
					end else begin
						rom_bank_q <= {value[1:0], rom_bank_q[4:0]};
					end
				end
				cbc_pkg::RGN_ROM_HI2: begin
					banking_mode_q <= value[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/cartridge_bank_controller_unit.sv
// Top level of the cartridge bank controller: request pipeline, memories, config port.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    cmd, address, value, image_address
//   rsp      out  valid / ready    read_data (one per CPU read)
//   apb      in   psel / penable   ram_present at byte address 0
//
// One request per cycle when not stalled; a CPU read returns its byte after acceptance
// through the registered memory read and then the output register.
// After reset a sweep zeroes all RamBytes bytes of cartridge RAM one byte a cycle,
// with req.ready held low; config writes are taken during the sweep.
// A stalled response holds the read stage, which holds off new requests.
// Sizes are powers of two; ROM and RAM offsets wrap at the memory size.
`timescale 1ns / 1ps

module cartridge_bank_controller_unit #(
	parameter int RomBytes = cbc_pkg::ROM_BYTES_DEF,
	parameter int RamBytes = cbc_pkg::RAM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cbc_req_if.sink     req,
	cbc_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RomAw = $clog2(RomBytes);
	localparam int RamAw = $clog2(RamBytes);

	cbc_pkg::acc_t acc;

	logic             accept;
	logic             advance;
	logic             ram_present_q;
	logic             clr_busy_q;
	logic [RamAw-1:0] clr_cnt_q;
	logic             valid_s1;
	logic [1:0]       src_s1;
	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic [7:0]       rom_rd_data;
	logic [7:0]       ram_rd_data;
	logic [7:0]       sel_data;
	logic             cfg_wr;

	logic             ram_wr_en;
	logic [RamAw-1:0] ram_wr_addr;
	logic [7:0]       ram_wr_data;

	// Handshakes
	assign advance   = !out_valid_q || rsp.ready;
	assign req.ready = !clr_busy_q && (!valid_s1 || advance);
	assign accept    = req.valid && req.ready;

	cbc_decode #(
		.RomBytes (RomBytes)
	) u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.cmd           (req.cmd),
		.address       (req.address),
		.value         (req.value),
		.image_address (req.image_address),
		.ram_present   (ram_present_q),
		.acc           (acc)
	);

	cbc_ram #(
		.Width (8),
		.Depth (RomBytes)
	) u_rom (
		.clk     (clk),
		.wr_en   (accept && acc.rom_wr),
		.wr_addr (RomAw'(acc.rom_off)),
		.wr_data (req.value),
		.rd_en   (accept && acc.rom_rd),
		.rd_addr (RomAw'(acc.rom_off)),
		.rd_data (rom_rd_data)
	);

	// Clearing sweep owns the RAM write port after reset
	assign ram_wr_en   = clr_busy_q || (accept && acc.ram_wr);
	assign ram_wr_addr = clr_busy_q ? clr_cnt_q : RamAw'(acc.ram_off);
	assign ram_wr_data = clr_busy_q ? 8'd0 : req.value;

	cbc_ram #(
		.Width (8),
		.Depth (RamBytes)
	) u_cart_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (accept && acc.ram_rd),
		.rd_addr (RamAw'(acc.ram_off)),
		.rd_data (ram_rd_data)
	);

	// Advance the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == RamAw'(RamBytes - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Read stage: track the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (req.cmd == cbc_pkg::CMD_READ);
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1 <= acc.src;
		end
	end

	// Pick the byte for the response
	always_comb begin
		case (src_s1)
			cbc_pkg::SRC_ROM: sel_data = rom_rd_data;
			cbc_pkg::SRC_RAM: sel_data = ram_rd_data;
			default:          sel_data = cbc_pkg::OPEN_BUS;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= sel_data;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;

	// Config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == cbc_pkg::REG_RAM_PRESENT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_present_q <= 1'b1;
		end else if (cfg_wr) begin
			ram_present_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == cbc_pkg::REG_RAM_PRESENT) ? {31'd0, ram_present_q} : 32'd0;

endmodule
